// ===== hw/rtl/crciv_pkg.sv =====
package crciv_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CRC_W    = 32;
    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [CRC_W-1:0]   CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0]   CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [COUNT_W-1:0] IMAGE_LENGTH_RESET = 32'd1;
    localparam logic [CRC_W-1:0]   EXPECTED_CRC_RESET = 32'd0;

    // Register indexes of the configuration channel.
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_LENGTH = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_CRC = 8'd1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_MATCH     = 2'd0,
        STATUS_MISMATCH  = 2'd1,
        STATUS_UNCHECKED = 2'd2
    } status_t;

    // Folds one byte into a reflected CRC-32 register, one bit per step.
    function automatic logic [CRC_W-1:0] fold_byte(
        input logic [CRC_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] data_in
    );
        logic [CRC_W-1:0] crc;
        crc = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data_in};
        for (int k = 0; k < BYTE_W; k++) begin
            crc = (crc >> 1) ^ (crc[0] ? CRC_POLY : '0);
        end
        return crc;
    endfunction

endpackage

// ===== hw/rtl/crciv_if.sv =====
// Image byte channel.
interface crciv_in_if;
    logic                              valid;
    logic                              ready;
    logic [crciv_pkg::BYTE_W-1:0]      data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// Result channel.
interface crciv_out_if;
    logic                              valid;
    logic                              ready;
    logic [crciv_pkg::CRC_W-1:0]       crc_value;
    logic [crciv_pkg::STATUS_W-1:0]    check_status;

    modport source (output valid, output crc_value, output check_status, input ready);
    modport sink   (input valid, input crc_value, input check_status, output ready);
endinterface

// Configuration write channel.
interface crciv_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [crciv_pkg::CFG_INDEX_W-1:0] index;
    logic [crciv_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/crc32_image_verifier_core.sv =====
// Channel   Direction  Word contents
// -------   ---------  ---------------------------------------------
// image     in         data_byte: next byte of the firmware image
// result    out        crc_value, check_status: one word per image
// cfg       in         index, data: register write (0 length, 1 CRC)
//
// One image byte is taken per clock cycle; the byte-wide CRC update is a
// single eight-step XOR network in front of the CRC register.
// The result word appears in the cycle after the closing byte.
// Reset (rst_n low) restores length one, expected CRC zero, CRC all ones.
// A held result only stalls the byte that would close the next image;
// all other bytes keep flowing. Configuration writes are always taken.
module crc32_image_verifier_core (
    input  logic          clk,
    input  logic          rst_n,
    crciv_in_if.sink      image,
    crciv_out_if.source   result,
    crciv_cfg_if.sink     cfg
);
    import crciv_pkg::*;

    // Configuration registers.
    logic [COUNT_W-1:0] image_length_reg;
    logic [CRC_W-1:0]   expected_crc_reg;

    // Running state of the current image.
    logic [CRC_W-1:0]   crc_reg;
    logic [CRC_W-1:0]   crc_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    // Result register.
    logic               result_valid_reg;
    logic [CRC_W-1:0]   crc_value_reg;
    status_t            check_status_reg;

    logic [CRC_W-1:0]   folded;
    logic [CRC_W-1:0]   closing_crc;
    logic [COUNT_W-1:0] count_inc;
    logic               closes;
    logic               image_accept;
    status_t            status_next;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_length_reg <= IMAGE_LENGTH_RESET;
            expected_crc_reg <= EXPECTED_CRC_RESET;
        end
        else if (cfg.valid)
        begin
            // Writes to an index beyond the register list are dropped.
            if (cfg.index == CFG_IMAGE_LENGTH)
            begin
                image_length_reg <= cfg.data;
            end
            else if (cfg.index == CFG_EXPECTED_CRC)
            begin
                expected_crc_reg <= cfg.data;
            end
        end
    end

    // The byte count wraps at 32 bits. The closing test is a plain
    // less-than on the incremented count, so a length of zero, or a length
    // lowered below the bytes already taken, closes the image on the next
    // byte.
    assign count_inc = count_reg + 1'b1;
    assign closes    = !(count_inc < image_length_reg);

    // Only a closing byte needs room in the result register.
    assign image.ready  = !(closes && result_valid_reg && !result.ready);
    assign image_accept = image.valid && image.ready;

    assign folded      = fold_byte(crc_reg, image.data_byte);
    assign closing_crc = ~folded;

    always_comb
    begin
        if (expected_crc_reg == '0)
        begin
            status_next = STATUS_UNCHECKED;
        end
        else if (closing_crc == expected_crc_reg)
        begin
            status_next = STATUS_MATCH;
        end
        else
        begin
            status_next = STATUS_MISMATCH;
        end
    end

    always_comb
    begin
        crc_next   = crc_reg;
        count_next = count_reg;
        if (image_accept)
        begin
            if (closes)
            begin
                crc_next   = CRC_INIT;
                count_next = '0;
            end
            else
            begin
                crc_next   = folded;
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= CRC_INIT;
            count_reg <= '0;
        end
        else
        begin
            crc_reg   <= crc_next;
            count_reg <= count_next;
        end
    end

    // Result register: loaded by a closing byte, emptied when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (image_accept && closes)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (image_accept && closes)
        begin
            crc_value_reg    <= closing_crc;
            check_status_reg <= status_next;
        end
    end

    assign result.valid        = result_valid_reg;
    assign result.crc_value    = crc_value_reg;
    assign result.check_status = check_status_reg;

endmodule
